// ----- rtl/c8080_pkg.sv -----
// c8080_pkg: shared types, codes and decode helpers for the 8080 subset step core.
// No dependencies; used by c8080_ctrl, c8080_dpath and cpu8080_subset_step_core.
`timescale 1ns / 1ps

package c8080_pkg;

	localparam int MEM_DEPTH_DEF = 65536;

	localparam logic [1:0] FN_EXEC  = 2'd0;
	localparam logic [1:0] FN_WRITE = 2'd1;
	localparam logic [1:0] FN_READ  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_HALT  = 2'd1;
	localparam logic [1:0] ST_UNIMP = 2'd2;

	localparam logic [7:0] OP_HLT = 8'h76;

	// supported opcode map, bit n set when opcode n is implemented
	localparam logic [255:0] OP_OK = {
		32'hE7270B63, 32'h212F27EF, 32'hFFF193A1, 32'h21037B6F,
		32'hFFFD73F7, 32'h4B6F3FFF, 32'hF747E77B, 32'h7F3FF7FF
	};

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] addr;
		logic [7:0]  write_data;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] prog_counter;
		logic [15:0] stack_ptr;
		logic [7:0]  accum;
		logic [15:0] pair_bc;
		logic [15:0] pair_de;
		logic [15:0] pair_hl;
		logic [4:0]  flag_bits;
		logic [7:0]  read_data;
	} result_t;

	typedef enum logic [3:0] {
		CMD_NONE, CMD_TAKE, CMD_MEMWR, CMD_MEMRD, CMD_RDLAT,
		CMD_FOP, CMD_FB1, CMD_FB2, CMD_LATB2, CMD_UNIMP,
		CMD_RD0, CMD_RD1, CMD_RDL, CMD_EXEC, CMD_WRB
	} cmd_t;

	typedef struct packed {
		logic halted;
		logic unimpl;
		logic need_rd;
		logic need_wr2;
	} dp_stat_t;

	function automatic logic [1:0] op_len(input logic [7:0] op);
		logic [1:0] n;
		n = 2'd1;
		if (op < 8'h40) begin
			if (op[3:0] == 4'h1 || op == 8'h22 || op == 8'h2a || op == 8'h32 || op == 8'h3a)
				n = 2'd3;
			else if (op[2:0] == 3'd6)
				n = 2'd2;
		end else if (op >= 8'hc0) begin
			if (op[2:0] == 3'd6 || op == 8'hd3 || op == 8'hdb)
				n = 2'd2;
			else if (op[2:0] == 3'd2 || op[2:0] == 3'd4 || op == 8'hc3 || op == 8'hcd)
				n = 2'd3;
		end
		return n;
	endfunction

endpackage

// ----- rtl/c8080_ctrl.sv -----
// c8080_ctrl: sequencer for one beat: memory write or read, or fetch, operand reads,
// execute, stack writes; each beat ends in a report. Depends on c8080_pkg.
`timescale 1ns / 1ps

module c8080_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          func,
	input  c8080_pkg::dp_stat_t st,
	output c8080_pkg::cmd_t     cmd,
	output logic                busy,
	output logic                done
);

	typedef enum logic [3:0] {
		S_IDLE, S_MEMWR, S_MEMRD, S_RDLAT, S_FOP, S_FB1, S_FB2, S_LATB2,
		S_DEC, S_RD0, S_RD1, S_RDL, S_EXEC, S_WRB, S_DONE
	} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (func == c8080_pkg::FN_EXEC && !st.halted) begin
							state_q <= S_FOP;
						end else if (func == c8080_pkg::FN_WRITE) begin
							state_q <= S_MEMWR;
						end else if (func == c8080_pkg::FN_READ) begin
							state_q <= S_MEMRD;
						end else begin
							state_q <= S_DONE;
							done_q  <= 1'b1;
						end
					end
				end
				S_MEMWR: begin
					state_q <= S_DONE;
					done_q  <= 1'b1;
				end
				S_MEMRD: state_q <= S_RDLAT;
				S_RDLAT: begin
					state_q <= S_DONE;
					done_q  <= 1'b1;
				end
				S_FOP:   state_q <= S_FB1;
				S_FB1:   state_q <= S_FB2;
				S_FB2:   state_q <= S_LATB2;
				S_LATB2: state_q <= S_DEC;
				S_DEC: begin
					if (st.unimpl) begin
						state_q <= S_DONE;
						done_q  <= 1'b1;
					end else if (st.need_rd) begin
						state_q <= S_RD0;
					end else begin
						state_q <= S_EXEC;
					end
				end
				S_RD0: state_q <= S_RD1;
				S_RD1: state_q <= S_RDL;
				S_RDL: state_q <= S_EXEC;
				S_EXEC: begin
					if (st.need_wr2) begin
						state_q <= S_WRB;
					end else begin
						state_q <= S_DONE;
						done_q  <= 1'b1;
					end
				end
				S_WRB: begin
					state_q <= S_DONE;
					done_q  <= 1'b1;
				end
				S_DONE:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		unique case (state_q)
			S_IDLE:  cmd = start ? c8080_pkg::CMD_TAKE : c8080_pkg::CMD_NONE;
			S_MEMWR: cmd = c8080_pkg::CMD_MEMWR;
			S_MEMRD: cmd = c8080_pkg::CMD_MEMRD;
			S_RDLAT: cmd = c8080_pkg::CMD_RDLAT;
			S_FOP:   cmd = c8080_pkg::CMD_FOP;
			S_FB1:   cmd = c8080_pkg::CMD_FB1;
			S_FB2:   cmd = c8080_pkg::CMD_FB2;
			S_LATB2: cmd = c8080_pkg::CMD_LATB2;
			S_DEC:   cmd = st.unimpl ? c8080_pkg::CMD_UNIMP : c8080_pkg::CMD_NONE;
			S_RD0:   cmd = c8080_pkg::CMD_RD0;
			S_RD1:   cmd = c8080_pkg::CMD_RD1;
			S_RDL:   cmd = c8080_pkg::CMD_RDL;
			S_EXEC:  cmd = c8080_pkg::CMD_EXEC;
			S_WRB:   cmd = c8080_pkg::CMD_WRB;
			default: cmd = c8080_pkg::CMD_NONE;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

`ifndef SYNTHESIS
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted beat did not raise busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("block not free after result");
	a_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == S_DONE) else $error("strobe outside report state");
`endif

endmodule

// ----- rtl/c8080_dpath.sv -----
// c8080_dpath: memory, architectural registers, decode and execute logic.
// Depends on c8080_pkg; driven by commands from c8080_ctrl.
`timescale 1ns / 1ps

module c8080_dpath #(
	parameter int MEM_DEPTH = c8080_pkg::MEM_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  c8080_pkg::cmd_t      cmd,
	input  c8080_pkg::item_t     item,
	output c8080_pkg::dp_stat_t  st,
	output c8080_pkg::result_t   result
);

	localparam int AW = $clog2(MEM_DEPTH);

	logic [7:0] mem_q [MEM_DEPTH];
	logic [7:0] rd_q;
	logic [15:0] mem_a;
	logic        mem_we;
	logic [7:0]  mem_wd;

	logic [15:0] pc_q, sp_q;
	logic [7:0]  b_q, c_q, d_q, e_q, h_q, l_q, a_q;
	logic [4:0]  flags_q;
	logic        halted_q;
	logic [1:0]  status_q;
	logic [7:0]  rdout_q;

	c8080_pkg::item_t item_q;
	logic [7:0]  op_q, b1_q, b2_q, d0_q, d1_q;
	logic [15:0] wa2_q;
	logic [7:0]  wd2_q;

	logic [15:0] bc, de, hl, imm, pv, sp_m1, sp_m2, sp_p2, pc_len, ra0, rp_val;
	logic [2:0]  x, src;
	logic [1:0]  rp;
	logic [7:0]  src_val, x_val, v8;
	logic        cnd;
	logic [16:0] dad;

	logic [15:0] nx_pc, nx_sp, wa0, wa2;
	logic [7:0]  nx_b, nx_c, nx_d, nx_e, nx_h, nx_l, nx_a, wd0, wd2;
	logic [4:0]  nx_f;
	logic        nx_halt, we0;
	logic [1:0]  exec_st;
	logic [12:0] alu_out;

	function automatic logic [7:0] sel_r(input logic [2:0] k, input logic [7:0] rb, rc, rd,
			re, rh, rl, rm, ra);
		logic [7:0] r;
		unique case (k)
			3'd0: r = rb;
			3'd1: r = rc;
			3'd2: r = rd;
			3'd3: r = re;
			3'd4: r = rh;
			3'd5: r = rl;
			3'd6: r = rm;
			default: r = ra;
		endcase
		return r;
	endfunction

	// {flags, result}
	function automatic logic [12:0] alu_f(input logic [2:0] k, input logic [7:0] a,
			input logic [7:0] v, input logic [4:0] f);
		logic [8:0] s;
		logic [7:0] nv, r;
		logic       cy, ac, cin;
		nv  = ~v;
		cin = f[3];
		s   = 9'd0;
		unique case (k)
			3'd0, 3'd1: begin
				s  = {1'b0, a} + {1'b0, v} + {8'd0, (k == 3'd1) & cin};
				r  = s[7:0];
				cy = s[8];
				ac = a[4] ^ v[4] ^ r[4];
			end
			3'd2, 3'd3, 3'd7: begin
				s  = {1'b0, a} + {1'b0, nv} + {8'd0, ~((k == 3'd3) & cin)};
				r  = s[7:0];
				cy = ~s[8];
				ac = a[4] ^ nv[4] ^ r[4];
			end
			3'd4: begin
				r  = a & v;
				cy = 1'b0;
				ac = a[3] | v[3];
			end
			3'd5: begin
				r  = a ^ v;
				cy = 1'b0;
				ac = 1'b0;
			end
			default: begin
				r  = a | v;
				cy = 1'b0;
				ac = 1'b0;
			end
		endcase
		return {ac, cy, ~^r, r[7], r == 8'd0, r};
	endfunction

	assign bc     = {b_q, c_q};
	assign de     = {d_q, e_q};
	assign hl     = {h_q, l_q};
	assign imm    = {b2_q, b1_q};
	assign pv     = {d1_q, d0_q};
	assign sp_m1  = sp_q - 16'd1;
	assign sp_m2  = sp_q - 16'd2;
	assign sp_p2  = sp_q + 16'd2;
	assign pc_len = pc_q + {14'd0, c8080_pkg::op_len(op_q)};
	assign x      = op_q[5:3];
	assign src    = op_q[2:0];
	assign rp     = op_q[5:4];
	assign src_val = sel_r(src, b_q, c_q, d_q, e_q, h_q, l_q, d0_q, a_q);
	assign x_val   = sel_r(x, b_q, c_q, d_q, e_q, h_q, l_q, d0_q, a_q);

	always_comb begin
		unique case (rp)
			2'd0: rp_val = bc;
			2'd1: rp_val = de;
			2'd2: rp_val = hl;
			default: rp_val = sp_q;
		endcase
		unique case (x)
			3'd0: cnd = ~flags_q[0];
			3'd1: cnd = flags_q[0];
			3'd2: cnd = ~flags_q[3];
			3'd3: cnd = flags_q[3];
			3'd4: cnd = ~flags_q[2];
			3'd5: cnd = flags_q[2];
			3'd6: cnd = ~flags_q[1];
			default: cnd = flags_q[1];
		endcase
	end

	// decode status and operand read address
	always_comb begin
		st.halted   = halted_q;
		st.unimpl   = ~c8080_pkg::OP_OK[op_q];
		st.need_rd  = 1'b0;
		st.need_wr2 = 1'b0;
		ra0         = hl;
		unique case (op_q[7:6])
			2'b01: st.need_rd = (src == 3'd6) && (op_q != c8080_pkg::OP_HLT);
			2'b10: st.need_rd = (src == 3'd6);
			2'b00: begin
				if (src == 3'd2 && x[0]) begin
					st.need_rd = 1'b1;
					ra0 = (x == 3'd1) ? bc : (x == 3'd3) ? de : imm;
				end else if ((src == 3'd4 || src == 3'd5) && x == 3'd6) begin
					st.need_rd = 1'b1;
				end
			end
			default: begin
				ra0 = sp_q;
				st.need_rd  = (src == 3'd0) ||
					(src == 3'd1 && (op_q == 8'hc9 || !op_q[3]));
				st.need_wr2 = (src == 3'd5 && (op_q == 8'hcd || !op_q[3])) || (src == 3'd7);
			end
		endcase
	end

	// execute: next architectural state
	always_comb begin
		nx_pc = pc_len;
		nx_sp = sp_q;
		nx_b = b_q; nx_c = c_q; nx_d = d_q; nx_e = e_q;
		nx_h = h_q; nx_l = l_q; nx_a = a_q;
		nx_f = flags_q;
		nx_halt = halted_q;
		exec_st = c8080_pkg::ST_OK;
		we0 = 1'b0;
		wa0 = hl;
		wd0 = 8'd0;
		wa2 = sp_m2;
		wd2 = 8'd0;
		v8  = 8'd0;
		dad = 17'd0;
		alu_out = alu_f(x, a_q, op_q[7:6] == 2'b10 ? src_val : b1_q, flags_q);
		if (op_q == c8080_pkg::OP_HLT) begin
			nx_halt = 1'b1;
			exec_st = c8080_pkg::ST_HALT;
		end else begin
			unique case (op_q[7:6])
				2'b01: v8 = src_val;
				2'b10: begin
					nx_f = alu_out[12:8];
					if (x != 3'd7) nx_a = alu_out[7:0];
				end
				2'b00: begin
					unique case (src)
						3'd1: begin
							if (op_q[3]) begin
								dad  = {1'b0, hl} + {1'b0, rp_val};
								nx_f[3] = dad[16];
								nx_h = dad[15:8];
								nx_l = dad[7:0];
							end else begin
								unique case (rp)
									2'd0: {nx_b, nx_c} = imm;
									2'd1: {nx_d, nx_e} = imm;
									2'd2: {nx_h, nx_l} = imm;
									default: nx_sp = imm;
								endcase
							end
						end
						3'd2: begin
							unique case (x)
								3'd0: begin we0 = 1'b1; wa0 = bc;  wd0 = a_q; end
								3'd2: begin we0 = 1'b1; wa0 = de;  wd0 = a_q; end
								3'd6: begin we0 = 1'b1; wa0 = imm; wd0 = a_q; end
								3'd5: begin nx_l = d0_q; nx_h = d1_q; end
								3'd4: ;
								default: nx_a = d0_q;
							endcase
						end
						3'd3: begin
							unique case (rp)
								2'd0: {nx_b, nx_c} = op_q[3] ? bc - 16'd1 : bc + 16'd1;
								2'd1: {nx_d, nx_e} = op_q[3] ? de - 16'd1 : de + 16'd1;
								2'd2: {nx_h, nx_l} = op_q[3] ? hl - 16'd1 : hl + 16'd1;
								default: nx_sp = op_q[3] ? sp_q - 16'd1 : sp_q + 16'd1;
							endcase
						end
						3'd4, 3'd5: begin
							v8 = (src == 3'd4) ? x_val + 8'd1 : x_val - 8'd1;
							nx_f = {(src == 3'd4) ? (v8[3:0] == 4'h0) : (v8[3:0] != 4'hf),
								flags_q[3], ~^v8, v8[7], v8 == 8'd0};
						end
						3'd6: v8 = b1_q;
						3'd7: begin
							unique case (x)
								3'd0: begin nx_f[3] = a_q[7]; nx_a = {a_q[6:0], a_q[7]}; end
								3'd1: begin nx_f[3] = a_q[0]; nx_a = {a_q[0], a_q[7:1]}; end
								3'd5: nx_a = ~a_q;
								3'd7: nx_f[3] = ~flags_q[3];
								default: ;
							endcase
						end
						default: ;
					endcase
				end
				default: begin
					unique case (src)
						3'd0: if (cnd) begin nx_pc = pv; nx_sp = sp_p2; end
						3'd1: begin
							if (op_q == 8'hc9) begin
								nx_pc = pv; nx_sp = sp_p2;
							end else if (op_q == 8'he9) begin
								nx_pc = hl;
							end else if (op_q == 8'hf9) begin
								nx_sp = hl;
							end else if (!op_q[3]) begin
								nx_sp = sp_p2;
								unique case (rp)
									2'd0: {nx_b, nx_c} = pv;
									2'd1: {nx_d, nx_e} = pv;
									2'd2: {nx_h, nx_l} = pv;
									default: begin nx_a = d1_q; nx_f = d0_q[4:0]; end
								endcase
							end
						end
						3'd2: if (cnd) nx_pc = imm;
						3'd3: begin
							if (op_q == 8'hc3) begin
								nx_pc = imm;
							end else if (op_q == 8'heb) begin
								{nx_d, nx_e} = hl;
								{nx_h, nx_l} = de;
							end
						end
						3'd5: begin
							if (op_q == 8'hcd || !op_q[3]) begin
								nx_sp = sp_m2;
								we0 = 1'b1;
								wa0 = sp_m1;
								if (op_q == 8'hcd) begin
									nx_pc = imm;
									wd0 = pc_len[15:8];
									wd2 = pc_len[7:0];
								end else if (rp == 2'd3) begin
									wd0 = a_q;
									wd2 = {3'd0, flags_q};
								end else begin
									wd0 = rp_val[15:8];
									wd2 = rp_val[7:0];
								end
							end
						end
						3'd6: begin
							nx_f = alu_out[12:8];
							if (x != 3'd7) nx_a = alu_out[7:0];
						end
						3'd7: begin
							nx_sp = sp_m2;
							we0 = 1'b1;
							wa0 = sp_m1;
							wd0 = pc_len[15:8];
							wd2 = pc_len[7:0];
							nx_pc = {10'd0, op_q[5:3], 3'd0};
						end
						default: ;
					endcase
				end
			endcase
			// register write-back for MOV, INR, DCR and MVI
			if (op_q[7:6] == 2'b01 ||
					(op_q[7:6] == 2'b00 && (src == 3'd4 || src == 3'd5 || src == 3'd6))) begin
				unique case (x)
					3'd0: nx_b = v8;
					3'd1: nx_c = v8;
					3'd2: nx_d = v8;
					3'd3: nx_e = v8;
					3'd4: nx_h = v8;
					3'd5: nx_l = v8;
					3'd6: begin we0 = 1'b1; wa0 = hl; wd0 = v8; end
					default: nx_a = v8;
				endcase
			end
		end
	end

	// single memory port
	always_comb begin
		mem_we = 1'b0;
		mem_wd = wd0;
		unique case (cmd)
			c8080_pkg::CMD_MEMWR: begin
				mem_a = item_q.addr; mem_we = 1'b1; mem_wd = item_q.write_data;
			end
			c8080_pkg::CMD_MEMRD: mem_a = item_q.addr;
			c8080_pkg::CMD_FOP:   mem_a = pc_q;
			c8080_pkg::CMD_FB1:   mem_a = pc_q + 16'd1;
			c8080_pkg::CMD_FB2:   mem_a = pc_q + 16'd2;
			c8080_pkg::CMD_RD0:   mem_a = ra0;
			c8080_pkg::CMD_RD1:   mem_a = ra0 + 16'd1;
			c8080_pkg::CMD_EXEC: begin
				mem_a = wa0; mem_we = we0;
			end
			c8080_pkg::CMD_WRB: begin
				mem_a = wa2_q; mem_we = 1'b1; mem_wd = wd2_q;
			end
			default: mem_a = pc_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_a[AW-1:0]] <= mem_wd;
		rd_q <= mem_q[mem_a[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		unique case (cmd)
			c8080_pkg::CMD_TAKE:  item_q <= item;
			c8080_pkg::CMD_FB1:   op_q <= rd_q;
			c8080_pkg::CMD_FB2:   b1_q <= rd_q;
			c8080_pkg::CMD_LATB2: b2_q <= rd_q;
			c8080_pkg::CMD_RD1:   d0_q <= rd_q;
			c8080_pkg::CMD_RDL:   d1_q <= rd_q;
			c8080_pkg::CMD_EXEC: begin
				wa2_q <= wa2;
				wd2_q <= wd2;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0; sp_q <= '0;
			b_q <= '0; c_q <= '0; d_q <= '0; e_q <= '0;
			h_q <= '0; l_q <= '0; a_q <= '0;
			flags_q <= '0; halted_q <= 1'b0;
			status_q <= c8080_pkg::ST_OK;
			rdout_q <= '0;
		end else begin
			unique case (cmd)
				c8080_pkg::CMD_TAKE: begin
					status_q <= halted_q ? c8080_pkg::ST_HALT : c8080_pkg::ST_OK;
					rdout_q  <= '0;
				end
				c8080_pkg::CMD_RDLAT: rdout_q <= rd_q;
				c8080_pkg::CMD_UNIMP: status_q <= c8080_pkg::ST_UNIMP;
				c8080_pkg::CMD_EXEC: begin
					pc_q <= nx_pc; sp_q <= nx_sp;
					b_q <= nx_b; c_q <= nx_c; d_q <= nx_d; e_q <= nx_e;
					h_q <= nx_h; l_q <= nx_l; a_q <= nx_a;
					flags_q <= nx_f; halted_q <= nx_halt;
					status_q <= exec_st;
				end
				default: ;
			endcase
		end
	end

	assign result.status       = status_q;
	assign result.prog_counter = pc_q;
	assign result.stack_ptr    = sp_q;
	assign result.accum        = a_q;
	assign result.pair_bc      = bc;
	assign result.pair_de      = de;
	assign result.pair_hl      = hl;
	assign result.flag_bits    = flags_q;
	assign result.read_data    = rdout_q;

endmodule

// ----- rtl/cpu8080_subset_step_core.sv -----
// cpu8080_subset_step_core: top level of the 8080 subset step core.
// Depends on c8080_pkg, c8080_ctrl and c8080_dpath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------
//  command  | start, busy          | item   (c8080_pkg::item_t)
//  result   | done (1-cycle pulse) | result (c8080_pkg::result_t)
//
// A beat is taken on the edge where start is high and busy is low; busy then
// stays high until the result cycle has passed.
// Memory write, memory read, execute while halted or func 3, an unimplemented
// opcode and execute each take their own state sequence; execute adds an
// operand read (M, LDAX, LDA, LHLD, POP, RET) and a second stack write
// (PUSH, CALL, RST) where needed. All memory traffic shares the single port:
// opcode, two operand bytes, two data bytes and two stack bytes go through it
// one per cycle. Reset clears PC, SP, registers, flags and halt; memory holds
// whatever was written. The result receiver cannot stall: done lasts one cycle.
`timescale 1ns / 1ps

module cpu8080_subset_step_core #(
	parameter int MEM_DEPTH = c8080_pkg::MEM_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  c8080_pkg::item_t   item,
	output logic               busy,
	output logic               done,
	output c8080_pkg::result_t result
);

	c8080_pkg::cmd_t     cmd;
	c8080_pkg::dp_stat_t st;

	// sequence each beat through the shared memory port
	c8080_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (item.func),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// hold architectural state and memory, advance on command
	c8080_dpath #(
		.MEM_DEPTH (MEM_DEPTH)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.st     (st),
		.result (result)
	);

endmodule
